// ===== design/sacl_pkg.sv =====
`default_nettype none

package sacl_pkg;

    localparam int DEF_MAX_WAYS   = 4;
    localparam int DEF_MAX_SETS   = 128;
    localparam int DEF_ADDR_WIDTH = 32;

    localparam int CNT_W     = 48;
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] RST_OFFSET_BITS = 3'd2;
    localparam logic [CFG_W-1:0] RST_INDEX_BITS  = 3'd0;
    localparam logic [CFG_W-1:0] RST_WAYS        = 3'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET = 2'd0,
        CFG_INDEX  = 2'd1,
        CFG_WAYS   = 2'd2
    } t_cfg_idx;

    typedef logic [CNT_W-1:0] t_cnt;

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == '1) ? v : v + t_cnt'(1);
    endfunction

endpackage

`default_nettype wire

// ===== design/sacl_lookup.sv =====
`default_nettype none

module sacl_lookup #(
    parameter int NWAYS = 4,
    parameter int TW    = 32,
    parameter int AW    = 2
) (
    input  wire logic [NWAYS-1:0][TW+AW:0] i_row,
    input  wire logic [TW-1:0]             i_tag,
    input  wire logic [AW-1:0]             i_ways_m1,
    output logic [NWAYS-1:0][TW+AW:0]      o_row,
    output logic                           o_hit,
    output logic [AW-1:0]                  o_way
);

    typedef struct packed {
        logic          valid;
        logic [TW-1:0] tag;
        logic [AW-1:0] age;
    } t_line;

    t_line [NWAYS-1:0] row;
    t_line [NWAYS-1:0] nrow;

    assign row   = i_row;
    assign o_row = nrow;

    always_comb begin
        logic          hit;
        logic          found;
        logic [AW-1:0] hway;
        logic [AW-1:0] fway;
        logic [AW-1:0] best;
        logic [AW-1:0] way;
        logic [AW-1:0] limit;
        logic          unlimited;
        hit   = 1'b0;
        found = 1'b0;
        hway  = '0;
        fway  = '0;
        best  = '0;
        for (int i = 0; i < NWAYS; i++) begin
            if (AW'(i) <= i_ways_m1) begin
                if (!hit && row[i].valid && row[i].tag == i_tag) begin
                    hit  = 1'b1;
                    hway = AW'(i);
                end
                if (!found && !row[i].valid) begin
                    found = 1'b1;
                    fway  = AW'(i);
                end
                if (row[i].age > row[best].age) begin
                    best = AW'(i);
                end
            end
        end
        way       = hit ? hway : (found ? fway : best);
        unlimited = !hit && found;
        limit     = row[way].age;
        nrow      = row;
        for (int i = 0; i < NWAYS; i++) begin
            if (AW'(i) <= i_ways_m1 && AW'(i) != way && row[i].valid &&
                (unlimited || row[i].age < limit) && row[i].age < i_ways_m1) begin
                nrow[i].age = row[i].age + AW'(1);
            end
        end
        nrow[way].age = '0;
        if (!hit) begin
            nrow[way].valid = 1'b1;
            nrow[way].tag   = i_tag;
        end
        o_hit = hit;
        o_way = way;
    end

endmodule

`default_nettype wire

// ===== design/set_assoc_cache_lru_lookup_top.sv =====
// Tag-only set-associative cache lookup with true LRU replacement.
//
// Lookup channel: drive i_address with start high; the word is taken at a
// rising edge where start is high and busy is low. busy is low whenever the
// block is out of reset, so one address may be issued every cycle.
// Result channel: o_done is high for exactly one cycle, after the s1 and
// output registers, with o_hit, o_way_used and the three running totals.
// The receiver cannot stall; results are in issue order, one per address.
// Throughput 1 address per cycle: one read of the set row
// from the tag RAM, then compare, LRU update and write-back of that row in
// the following cycle; a set-row bypass covers back-to-back accesses to a set.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_wdata; write only while idle.
// Reset (synchronous, active low) clears the totals, the per-set row-valid
// flags (so every line reads invalid) and restores the default
// configuration. No clearing sweep of the RAM is needed; lookups may start
// on the first cycle after reset.
`default_nettype none

module set_assoc_cache_lru_lookup_top #(
    parameter int MAX_WAYS   = sacl_pkg::DEF_MAX_WAYS,
    parameter int MAX_SETS   = sacl_pkg::DEF_MAX_SETS,
    parameter int ADDR_WIDTH = sacl_pkg::DEF_ADDR_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [31:0]                    i_address,
    input  wire logic                           i_cfg_we,
    input  wire logic [sacl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sacl_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                                o_done,
    output logic                                o_hit,
    output logic [1:0]                          o_way_used,
    output logic [sacl_pkg::CNT_W-1:0]          o_access_total,
    output logic [sacl_pkg::CNT_W-1:0]          o_hit_total,
    output logic [sacl_pkg::CNT_W-1:0]          o_miss_total
);

    import sacl_pkg::*;

    localparam int TW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam int AW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int LW = TW + AW + 1;
    localparam logic [AW-1:0] WAYS_M1_MAX = AW'(MAX_WAYS - 1);

    typedef logic [MAX_WAYS-1:0][LW-1:0] t_row;

    logic [CFG_W-1:0] r_cfg_off;
    logic [CFG_W-1:0] r_cfg_idx;
    logic [CFG_W-1:0] r_cfg_ways;

    logic          accept;
    logic [SW-1:0] set_c;
    logic [TW-1:0] tag_c;

    logic          r_s1_vld;
    logic [SW-1:0] r_s1_set;
    logic [TW-1:0] r_s1_tag;

    t_row          r_mem [MAX_SETS];
    t_row          r_rd_row;
    t_row          r_byp_row;
    logic          r_byp;
    logic          r_init_rd;
    logic [MAX_SETS-1:0] r_row_init;

    t_row          cur_row;
    t_row          n_row;
    logic          lk_hit;
    logic [AW-1:0] lk_way;
    logic [AW-1:0] ways_m1;

    logic          r_out_vld;
    logic          r_out_hit;
    logic [1:0]    r_out_way;
    t_cnt          r_acc;
    t_cnt          r_hits;
    t_cnt          r_miss;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    // set = (addr >> off) & mask, folded onto the stored sets by a constant table
    always_comb begin
        logic [TW-1:0] a;
        logic [6:0]    sv;
        logic [6:0]    mask;
        logic [3:0]    sh;
        a     = i_address[TW-1:0];
        mask  = 7'((8'd1 << r_cfg_idx) - 8'd1);
        sv    = 7'(a >> r_cfg_off) & mask;
        set_c = '0;
        for (int k = 0; k < 128; k++) begin
            if (sv == 7'(k)) begin
                set_c = SW'(k % MAX_SETS);
            end
        end
        sh    = {1'b0, r_cfg_off} + {1'b0, r_cfg_idx};
        tag_c = TW'(a >> sh);
    end

    always_comb begin
        logic [CFG_W-1:0] ws;
        ws = (r_cfg_ways == '0) ? CFG_W'(1) : r_cfg_ways;
        if (int'(ws) > MAX_WAYS) begin
            ways_m1 = WAYS_M1_MAX;
        end else begin
            ways_m1 = AW'(ws - CFG_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_mem[r_s1_set] <= n_row;
        end
        r_rd_row <= r_mem[set_c];
    end

    assign cur_row = r_byp ? r_byp_row : (r_init_rd ? r_rd_row : '0);

    sacl_lookup #(
        .NWAYS (MAX_WAYS),
        .TW    (TW),
        .AW    (AW)
    ) u_lookup (
        .i_row     (cur_row),
        .i_tag     (r_s1_tag),
        .i_ways_m1 (ways_m1),
        .o_row     (n_row),
        .o_hit     (lk_hit),
        .o_way     (lk_way)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_off  <= RST_OFFSET_BITS;
            r_cfg_idx  <= RST_INDEX_BITS;
            r_cfg_ways <= RST_WAYS;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_byp      <= 1'b0;
            r_row_init <= '0;
            r_acc      <= '0;
            r_hits     <= '0;
            r_miss     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OFFSET: r_cfg_off  <= i_cfg_wdata;
                    CFG_INDEX:  r_cfg_idx  <= i_cfg_wdata;
                    CFG_WAYS:   r_cfg_ways <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_s1_vld  <= accept;
            r_out_vld <= r_s1_vld;
            r_byp     <= r_s1_vld && (r_s1_set == set_c);
            if (r_s1_vld) begin
                r_row_init[r_s1_set] <= 1'b1;
                r_acc <= sat_inc(r_acc);
                if (lk_hit) begin
                    r_hits <= sat_inc(r_hits);
                end else begin
                    r_miss <= sat_inc(r_miss);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_set  <= set_c;
        r_s1_tag  <= tag_c;
        r_init_rd <= r_row_init[set_c];
        r_byp_row <= n_row;
        r_out_hit <= lk_hit;
        r_out_way <= 2'(lk_way);
    end

    assign o_done         = r_out_vld;
    assign o_hit          = r_out_hit;
    assign o_way_used     = r_out_way;
    assign o_access_total = r_acc;
    assign o_hit_total    = r_hits;
    assign o_miss_total   = r_miss;

endmodule

`default_nettype wire

// ===== design/sacl_checker.sv =====
`default_nettype none

module sacl_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       o_done,
    input wire logic [sacl_pkg::CNT_W-1:0] o_access_total,
    input wire logic [sacl_pkg::CNT_W-1:0] o_hit_total,
    input wire logic [sacl_pkg::CNT_W-1:0] o_miss_total
);

    import sacl_pkg::*;

    // every accepted word yields a result on o_done
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("result missing after accepted word");

    // no result on o_done without an earlier accepted word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result without accepted word");

    // below saturation, accesses split exactly into hits and misses
    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_access_total != '1) |->
        ({1'b0, o_hit_total} + {1'b0, o_miss_total} == {1'b0, o_access_total}))
        else $error("hit and miss totals do not add up");

    // consecutive results advance the access total by one unless saturated
    a_acc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(o_done) && $past(o_access_total) != '1) |->
        (o_access_total == $past(o_access_total) + t_cnt'(1)))
        else $error("access total did not advance by one");

endmodule

bind set_assoc_cache_lru_lookup_top sacl_checker u_sacl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_access_total (o_access_total),
    .o_hit_total    (o_hit_total),
    .o_miss_total   (o_miss_total)
);

`default_nettype wire
